@@ design/bost_pkg.sv @@
// ----------------------------------------------------------------------------
// bost_pkg: shared types and constants for the box overlap slot table
// Command and filter codes, stream field layout, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bost_pkg;

  // Default table size and coordinate width
  localparam int DEF_SLOTS      = 1024;
  localparam int DEF_COORD_BITS = 16;

  // Command codes (carried in the input tuser)
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_FIND    = 3'd1;
  localparam logic [2:0] OP_DESTROY = 3'd2;
  localparam logic [2:0] OP_SWEEP   = 3'd3;
  localparam logic [2:0] OP_MOVE    = 3'd4;

  // Find filter codes
  localparam logic [1:0] FLT_TAG   = 2'd0;
  localparam logic [1:0] FLT_ANY   = 2'd1;
  localparam logic [1:0] FLT_SOLID = 2'd2;
  localparam logic [1:0] FLT_KILL  = 2'd3;

  // Field widths fixed by the stream format
  localparam int FIELD_COORD_W = 16;
  localparam int FIELD_SLOT_W  = 10;
  localparam int CMD_W         = 3;

  // Input tdata layout, lowest bit first
  localparam int POS_X_LSB  = 0;
  localparam int POS_Y_LSB  = 16;
  localparam int SIZE_W_LSB = 32;
  localparam int SIZE_H_LSB = 48;
  localparam int TAG_LSB    = 64;
  localparam int MODE_LSB   = 72;
  localparam int SOLID_BIT  = 74;
  localparam int KILL_BIT   = 75;
  localparam int EXCL_V_BIT = 76;
  localparam int EXCL_LSB   = 77;
  localparam int TARGET_LSB = 87;
  localparam int IN_TDATA_W = 104;

  // Output tdata layout, lowest bit first
  localparam int FOUND_BIT  = 0;
  localparam int SLOT_LSB   = 1;
  localparam int FULL_BIT   = 11;
  localparam int OUT_TDATA_W = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;    // clear both flag entries of one slot at the clear counter
    logic load;     // capture the accepted request
    logic exec;     // run a single-slot command and zero the result
    logic scan;     // step the table scan
    logic capture;  // end the scan and latch its result
    logic emit;     // move the latched result into the output register
  } bost_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_op;  // held command walks the table
    logic hit;      // slot under evaluation ends the scan
    logic last;     // slot under evaluation is the final one
    logic clr_done; // clearing pass writes its final entry
  } bost_stat_t;

endpackage

@@ design/bost_ctrl.sv @@
// ----------------------------------------------------------------------------
// bost_ctrl: sequencer for the box overlap slot table
// Runs the clearing pass after reset, takes one request at a time, steps the
// table scan and hands finished results to the output register.
// ----------------------------------------------------------------------------
module bost_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  bost_pkg::bost_stat_t stat,
  output bost_pkg::bost_ctrl_t ctrl
);
  import bost_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Decode commands and next state
  always_comb begin
    ctrl      = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        ctrl.clear = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.scan_op) begin
          state_nxt = S_SCAN;
        end else begin
          ctrl.exec = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.hit || stat.last) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          ctrl.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the output valid until the result is taken
  always_comb begin
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ design/bost_dp.sv @@
// ----------------------------------------------------------------------------
// bost_dp: datapath of the box overlap slot table
// Holds the slot memories, the request registers, the scan counter, the
// per-slot overlap and filter test, and the result and output registers.
// ----------------------------------------------------------------------------
module bost_dp #(
  parameter int SLOTS      = bost_pkg::DEF_SLOTS,
  parameter int COORD_BITS = bost_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bost_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [bost_pkg::CMD_W-1:0]        in_tuser,
  input  bost_pkg::bost_ctrl_t              ctrl,
  output bost_pkg::bost_stat_t              stat,
  output logic [bost_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import bost_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int EXW   = IDX_W + FIELD_SLOT_W;
  localparam int POS_W = 2 * C;
  localparam int SA_W  = 2 * C + 10;

  // Slot memories: position, size and attributes, used and destroyed flags
  logic [POS_W-1:0] pos_mem  [SLOTS];
  logic [SA_W-1:0]  sa_mem   [SLOTS];
  logic             used_mem [SLOTS];
  logic             dest_mem [SLOTS];

  // Request fields, coordinates cut to C bits as two's complement
  logic [31:0]         raw_x, raw_y, raw_w, raw_h;
  logic signed [C-1:0] in_x, in_y, in_w, in_h;
  logic signed [C:0]   in_xe, in_ye;

  assign raw_x = 32'(in_tdata[POS_X_LSB +: FIELD_COORD_W]);
  assign raw_y = 32'(in_tdata[POS_Y_LSB +: FIELD_COORD_W]);
  assign raw_w = 32'(in_tdata[SIZE_W_LSB +: FIELD_COORD_W]);
  assign raw_h = 32'(in_tdata[SIZE_H_LSB +: FIELD_COORD_W]);
  assign in_x  = raw_x[C-1:0];
  assign in_y  = raw_y[C-1:0];
  assign in_w  = raw_w[C-1:0];
  assign in_h  = raw_h[C-1:0];
  assign in_xe = {in_x[C-1], in_x} + {in_w[C-1], in_w};
  assign in_ye = {in_y[C-1], in_y} + {in_h[C-1], in_h};

  // Request registers
  logic [CMD_W-1:0]        op_r;
  logic signed [C-1:0]     qx_r, qy_r, qw_r, qh_r;
  logic signed [C:0]       qxe_r, qye_r;
  logic [7:0]              tag_r;
  logic [1:0]              mode_r;
  logic                    solid_r, kill_r, excl_on_r;
  logic [FIELD_SLOT_W-1:0] excl_r, target_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r      <= in_tuser;
      qx_r      <= in_x;
      qy_r      <= in_y;
      qw_r      <= in_w;
      qh_r      <= in_h;
      qxe_r     <= in_xe;
      qye_r     <= in_ye;
      tag_r     <= in_tdata[TAG_LSB +: 8];
      mode_r    <= in_tdata[MODE_LSB +: 2];
      solid_r   <= in_tdata[SOLID_BIT];
      kill_r    <= in_tdata[KILL_BIT];
      excl_on_r <= in_tdata[EXCL_V_BIT];
      excl_r    <= in_tdata[EXCL_LSB +: FIELD_SLOT_W];
      target_r  <= in_tdata[TARGET_LSB +: FIELD_SLOT_W];
    end
  end

  // Scan and clear counter, one slot per cycle
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] cnt_addr;
  logic             issue;
  logic             ev_v_r;
  logic [IDX_W-1:0] ev_idx_r;

  assign cnt_addr = cnt_r[IDX_W-1:0];
  assign issue    = ctrl.scan && !ctrl.capture && (cnt_r < CNT_W'(SLOTS));

  always_comb begin
    if (ctrl.load) begin
      cnt_nxt = '0;
    end else if (ctrl.clear || issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ev_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ev_v_r <= issue;
    end
  end

  // Read one slot a cycle; data lines up with ev_idx_r
  logic [POS_W-1:0] pos_rd_r;
  logic [SA_W-1:0]  sa_rd_r;
  logic             used_rd_r, dest_rd_r;

  always_ff @(posedge clk) begin
    ev_idx_r  <= cnt_addr;
    pos_rd_r  <= pos_mem[cnt_addr];
    sa_rd_r   <= sa_mem[cnt_addr];
    used_rd_r <= used_mem[cnt_addr];
    dest_rd_r <= dest_mem[cnt_addr];
  end

  // Evaluate the slot: overlap with inclusive bounds, filter, exclusion
  logic signed [C-1:0] ex, ey, ew, eh;
  logic signed [C:0]   ex_s, ey_s, qx_s, qy_s, exe, eye;
  logic [7:0]          e_tag;
  logic                e_solid, e_kill;
  logic                overlap, filt_ok, excl_hit, find_hit, add_hit, hit, last;

  assign ex      = pos_rd_r[C-1:0];
  assign ey      = pos_rd_r[POS_W-1:C];
  assign ew      = sa_rd_r[C-1:0];
  assign eh      = sa_rd_r[POS_W-1:C];
  assign e_tag   = sa_rd_r[POS_W +: 8];
  assign e_solid = sa_rd_r[POS_W + 8];
  assign e_kill  = sa_rd_r[POS_W + 9];

  assign ex_s = {ex[C-1], ex};
  assign ey_s = {ey[C-1], ey};
  assign qx_s = {qx_r[C-1], qx_r};
  assign qy_s = {qy_r[C-1], qy_r};
  assign exe  = ex_s + {ew[C-1], ew};
  assign eye  = ey_s + {eh[C-1], eh};

  assign overlap = (qx_s <= exe) && (ex_s <= qxe_r) && (qy_s <= eye) && (ey_s <= qye_r);

  always_comb begin
    case (mode_r)
      FLT_TAG:   filt_ok = (e_tag == tag_r);
      FLT_ANY:   filt_ok = 1'b1;
      FLT_SOLID: filt_ok = e_solid;
      FLT_KILL:  filt_ok = e_kill;
      default:   filt_ok = 1'b0;
    endcase
  end

  assign excl_hit = excl_on_r && (EXW'(ev_idx_r) == EXW'(excl_r));
  assign find_hit = used_rd_r && !dest_rd_r && filt_ok && !excl_hit && overlap;
  assign add_hit  = !used_rd_r;
  assign hit      = ev_v_r && (((op_r == OP_ADD) && add_hit) ||
                               ((op_r == OP_FIND) && find_hit));
  assign last     = ev_v_r && (ev_idx_r == IDX_W'(SLOTS - 1));

  assign stat.scan_op  = (op_r == OP_ADD) || (op_r == OP_FIND) || (op_r == OP_SWEEP);
  assign stat.hit      = hit;
  assign stat.last     = last;
  assign stat.clr_done = ctrl.clear && (cnt_r == CNT_W'(SLOTS - 1));

  // Write requests
  logic             commit_add, sweep_free, tgt_ok, destroy_wr, move_wr;
  logic [IDX_W-1:0] tgt_addr;

  assign commit_add = ctrl.capture && (op_r == OP_ADD) && hit;
  assign sweep_free = ctrl.scan && ev_v_r && (op_r == OP_SWEEP) && used_rd_r && dest_rd_r;
  assign tgt_ok     = (32'(target_r) < 32'(SLOTS));
  assign tgt_addr   = IDX_W'(target_r);
  assign destroy_wr = ctrl.exec && (op_r == OP_DESTROY) && tgt_ok;
  assign move_wr    = ctrl.exec && (op_r == OP_MOVE) && tgt_ok;

  // Used flags: clear pass, add, sweep
  logic             used_we, used_wd;
  logic [IDX_W-1:0] used_wa;
  assign used_we = ctrl.clear || commit_add || sweep_free;
  assign used_wa = ctrl.clear ? cnt_addr : ev_idx_r;
  assign used_wd = commit_add;

  // Destroyed flags: clear pass, add, destroy
  logic             dest_we, dest_wd;
  logic [IDX_W-1:0] dest_wa;
  assign dest_we = ctrl.clear || commit_add || destroy_wr;
  assign dest_wa = ctrl.clear ? cnt_addr : (destroy_wr ? tgt_addr : ev_idx_r);
  assign dest_wd = destroy_wr;

  // Position: add, move
  logic             pos_we;
  logic [IDX_W-1:0] pos_wa;
  assign pos_we = commit_add || move_wr;
  assign pos_wa = move_wr ? tgt_addr : ev_idx_r;

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (dest_we) begin
      dest_mem[dest_wa] <= dest_wd;
    end
    if (pos_we) begin
      pos_mem[pos_wa] <= {qy_r, qx_r};
    end
    if (commit_add) begin
      sa_mem[ev_idx_r] <= {kill_r, solid_r, tag_r, qh_r, qw_r};
    end
  end

  // Latch the result, then hand it to the output register
  logic                    res_found_r, res_full_r;
  logic [FIELD_SLOT_W-1:0] res_slot_r;
  logic                    out_found_r, out_full_r;
  logic [FIELD_SLOT_W-1:0] out_slot_r;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      res_found_r <= hit;
      res_slot_r  <= hit ? FIELD_SLOT_W'(ev_idx_r) : '0;
      res_full_r  <= (op_r == OP_ADD) && !hit;
    end else if (ctrl.exec) begin
      res_found_r <= 1'b0;
      res_slot_r  <= '0;
      res_full_r  <= 1'b0;
    end
    if (ctrl.emit) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
      out_full_r  <= res_full_r;
    end
  end

  assign out_tdata = {4'b0, out_full_r, out_slot_r, out_found_r};

endmodule

@@ design/box_overlap_slot_table.sv @@
// ----------------------------------------------------------------------------
// box_overlap_slot_table: table of axis-aligned boxes for collision queries
// Add, find (lowest overlapping slot through a filter), destroy, sweep and
// move on a fixed table of SLOTS slots held in on-chip memories.
//
//   channel | direction | tdata                       | tuser
//   --------+-----------+-----------------------------+------------
//   in_     | request   | box, tag, filter, exclusion | command
//   out_    | result    | found, result_slot, full    | -
//
// Add, find and sweep walk the slot memories one slot per cycle; add and find
// stop at their first hit. Destroy, move and unknown commands skip the walk.
// After reset a clearing pass over all SLOTS slots empties the flag memories;
// in_tready stays low until it ends. A new request is taken while a
// finished result still waits in the output register.
// ----------------------------------------------------------------------------
module box_overlap_slot_table #(
  parameter int SLOTS      = bost_pkg::DEF_SLOTS,
  parameter int COORD_BITS = bost_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x[15:0], pos_y[31:16], size_w[47:32], size_h[63:48], type_tag[71:64],
  // filter_mode[73:72], solid_mark[74], kill_mark[75], exclude_valid[76],
  // exclude_slot[86:77], target_slot[96:87], zero[103:97]
  input  logic [bost_pkg::IN_TDATA_W-1:0]   in_tdata,
  // command[2:0]
  input  logic [bost_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // found[0], result_slot[10:1], table_full[11], zero[15:12]
  output logic [bost_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import bost_pkg::*;

  bost_ctrl_t ctrl;
  bost_stat_t stat;

  // Sequencer
  bost_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // Slot memories and evaluation
  bost_dp #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

`ifndef SYNTHESIS
  // No request is taken during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !ctrl.clear)
    else $error("request accepted during clearing pass");

  // A scan ends only while it runs
  assert property (@(posedge clk) disable iff (!rst_n) ctrl.capture |-> ctrl.scan)
    else $error("scan result latched outside a scan");

  // A handed-over result shows as valid in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) ctrl.emit |=> out_tvalid)
    else $error("emitted result not presented");

  // A full table never reports a hit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[FOUND_BIT] && out_tdata[FULL_BIT]))
    else $error("found and table_full both set");
`endif

endmodule
